// File: rtl/core/i2csr_pkg.sv
`timescale 1ns / 1ps

package i2csr_pkg;

   // bus operations of a transaction program
   typedef enum logic [3:0] {
      OP_IDLE   = 4'd0,
      OP_START  = 4'd1,
      OP_STOP   = 4'd2,
      OP_WADDRW = 4'd3,
      OP_WADDRR = 4'd4,
      OP_WREG   = 4'd5,
      OP_W6B    = 4'd6,
      OP_W00    = 4'd7,
      OP_RACK   = 4'd8,
      OP_RNACK  = 4'd9
   } op_type;

   // configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;
   localparam logic [7:0] PHASE_TICKS_RESET    = 8'd100;
   localparam logic [7:0] REG_BASE_MINUS_TWO   = 8'h39;  // 0x3B - 2
   localparam logic [7:0] WAKE_REG             = 8'h6B;
   localparam logic [7:0] WAKE_VALUE           = 8'h00;
   localparam logic [3:0] WAKE_LEN             = 4'd5;
   localparam logic [3:0] READ_LEN             = 4'd8;
   localparam logic [3:0] LAST_BIT             = 4'd8;  // ack slot of a byte

   // one input tick
   typedef struct packed {
      logic       sda_in;
      logic [2:0] axis_index;
      logic       command;
      logic       request;
   } req_type;

   // one result tick
   typedef struct packed {
      logic               ack_missing;
      logic signed [15:0] sample;
      logic               done_res;
      logic               busy_res;
      logic               sda_drive;
      logic               sda_level;
      logic               scl_level;
   } rsp_type;

   function automatic op_type op_at(input logic [3:0] step, input logic cmd);
      op_type op;
      op = OP_IDLE;
      if (cmd) begin
         case (step)
            4'd1: op = OP_START;
            4'd2: op = OP_WADDRW;
            4'd3: op = OP_WREG;
            4'd4: op = OP_START;
            4'd5: op = OP_WADDRR;
            4'd6: op = OP_RACK;
            4'd7: op = OP_RNACK;
            4'd8: op = OP_STOP;
            default: op = OP_IDLE;
         endcase
      end else begin
         case (step)
            4'd1: op = OP_START;
            4'd2: op = OP_WADDRW;
            4'd3: op = OP_W6B;
            4'd4: op = OP_W00;
            4'd5: op = OP_STOP;
            default: op = OP_IDLE;
         endcase
      end
      return op;
   endfunction

endpackage

// File: rtl/core/i2c_sensor_register_reader.sv
`timescale 1ns / 1ps

// Pin-level I2C master that reads 16-bit sensor registers or sends a wake write.
// Every req transfer is one bus tick: it carries the request flags and the sampled
// SDA level, and yields exactly one rsp transfer with the SCL/SDA levels to drive
// for that tick, busy/done flags, the last read sample and the ack-missing flag.
// req_tdata (low bit up): request, command, axis_index[2:0], sda_in, zero pad.
// rsp_tdata (low bit up): scl_level, sda_level, sda_drive, busy_res, done_res,
//   sample[15:0], ack_missing, zero pad.
// The result of a tick is in the output register in the cycle after its
//   transfer. Throughput: one tick per cycle while results are taken; the sequencer
//   state update is a single pass of logic, so the only limit is the output register.
// A result waiting in the output register is still taken in the same cycle a new
//   tick is accepted; if the receiver stalls, req_tready drops until it is taken.
// csr port: index 0 device address (7 bits), index 1 phase ticks (0 acts as 1).
// Reset (synchronous): sequencer idle, SCL and SDA idle high with SDA driven,
//   address 104, 100 ticks per phase, sample and flags cleared, output empty.

module i2c_sensor_register_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // request, command, axis_index[2:0], sda_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // scl, sda_level, sda_drive, busy, done,
                                    // sample[15:0], ack_missing
);
   import i2csr_pkg::*;

   req_type tick_in;
   rsp_type tick_res;
   rsp_type rsp_data;
   logic    tick_accept;
   logic    out_full;

   assign tick_in     = req_type'(req_tdata[5:0]);
   assign req_tready  = !out_full || rsp_tready;
   assign tick_accept = req_tvalid && req_tready;

   i2csr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .tick_accept (tick_accept),
      .tick_in     (tick_in),
      .tick_out    (tick_res)
   );

   // result register: reloaded on every accepted tick, cleared when taken
   i2csr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (tick_accept),
      .load_data (tick_res),
      .full      (out_full),
      .take      (rsp_tready),
      .data      (rsp_data)
   );

   assign rsp_tvalid = out_full;
   assign rsp_tdata  = {2'b00, rsp_data};

endmodule

// File: rtl/core/i2csr_engine.sv
`timescale 1ns / 1ps

module i2csr_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [7:0]        csr_wdata,
   input  logic              tick_accept,
   input  i2csr_pkg::req_type tick_in,
   output i2csr_pkg::rsp_type tick_out
);
   import i2csr_pkg::*;

   logic [6:0]  dev_addr_ff;
   logic [7:0]  phase_ticks_ff;
   logic [3:0]  step_ff, step_in;
   logic [7:0]  pc_ff, pc_in;
   logic [3:0]  bc_ff, bc_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  regaddr_ff, regaddr_in;
   logic        cmd_ff, cmd_in;
   logic        nack_ff, nack_in;
   logic [15:0] sample_ff, sample_in;
   logic        half_ff, half_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEVICE_ADDRESS_RESET;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata[6:0];
            CSR_PHASE_TICKS:    phase_ticks_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      op_type     op;
      op_type     nop;
      logic [7:0] limit;
      logic       advance;
      logic       scl, lvl, drv, busy, done;

      step_in    = step_ff;
      pc_in      = pc_ff;
      bc_in      = bc_ff;
      shift_in   = shift_ff;
      high_in    = high_ff;
      regaddr_in = regaddr_ff;
      cmd_in     = cmd_ff;
      nack_in    = nack_ff;
      sample_in  = sample_ff;
      half_in    = half_ff;
      scl = 1'b1; lvl = 1'b1; drv = 1'b1; busy = 1'b0; done = 1'b0;
      advance = 1'b0;
      nop = OP_IDLE;

      // idle tick with a request: the transaction starts on this very tick
      if (step_ff == 4'd0 && tick_in.request) begin
         cmd_in     = tick_in.command;
         regaddr_in = REG_BASE_MINUS_TWO + {4'd0, tick_in.axis_index, 1'b0};
         nack_in    = 1'b0;
         step_in    = 4'd1;
         pc_in      = 8'd0;
         bc_in      = 4'd0;
         half_in    = 1'b0;
      end

      op = op_at(step_in, cmd_in);
      limit = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;

      if (op != OP_IDLE) begin
         busy = 1'b1;
         if (op == OP_START) begin
            scl = (bc_in != 4'd0);
            lvl = (bc_in != 4'd2);
         end else if (op == OP_STOP) begin
            scl = (bc_in != 4'd0);
            lvl = (bc_in == 4'd2);
         end else begin
            scl = half_in;
            if (op == OP_RACK || op == OP_RNACK) begin
               if (bc_in < LAST_BIT) drv = 1'b0;
               else                  lvl = (op == OP_RNACK);
            end else begin
               if (bc_in < LAST_BIT) lvl = shift_in[7];
               else                  drv = 1'b0;
            end
         end

         if ({1'b0, pc_in} + 9'd1 < {1'b0, limit}) begin
            pc_in = pc_in + 8'd1;
         end else begin
            pc_in = 8'd0;
            if (op == OP_START || op == OP_STOP) begin
               bc_in = bc_in + 4'd1;
               advance = (bc_in >= 4'd3);
            end else if (!half_in) begin
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               if (op == OP_RACK || op == OP_RNACK) begin
                  if (bc_in < LAST_BIT)   shift_in = {shift_in[6:0], tick_in.sda_in};
                  else if (op == OP_RACK) high_in = shift_in;
                  else                    sample_in = {high_in, shift_in};
               end else begin
                  if (bc_in < LAST_BIT)    shift_in = {shift_in[6:0], 1'b0};
                  else if (tick_in.sda_in) nack_in = 1'b1;
               end
               bc_in = bc_in + 4'd1;
               advance = (bc_in >= 4'd9);
            end
         end
      end

      if (advance) begin
         step_in = step_in + 4'd1;
         pc_in   = 8'd0;
         bc_in   = 4'd0;
         half_in = 1'b0;
         if (step_in > (cmd_in ? READ_LEN : WAKE_LEN)) begin
            step_in = 4'd0;
            done    = 1'b1;
         end else begin
            nop = op_at(step_in, cmd_in);
            case (nop)
               OP_WADDRW: shift_in = {dev_addr_ff, 1'b0};
               OP_WADDRR: shift_in = {dev_addr_ff, 1'b1};
               OP_WREG:   shift_in = regaddr_in;
               OP_W6B:    shift_in = WAKE_REG;
               OP_W00:    shift_in = WAKE_VALUE;
               OP_RACK,
               OP_RNACK:  shift_in = 8'd0;
               default:   ;
            endcase
         end
      end

      tick_out.scl_level   = scl;
      tick_out.sda_level   = lvl;
      tick_out.sda_drive   = drv;
      tick_out.busy_res    = busy;
      tick_out.done_res    = done;
      tick_out.sample      = sample_in;
      tick_out.ack_missing = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= 4'd0;
         pc_ff      <= 8'd0;
         bc_ff      <= 4'd0;
         shift_ff   <= 8'd0;
         high_ff    <= 8'd0;
         regaddr_ff <= 8'd0;
         cmd_ff     <= 1'b0;
         nack_ff    <= 1'b0;
         sample_ff  <= 16'd0;
         half_ff    <= 1'b0;
      end else if (tick_accept) begin
         step_ff    <= step_in;
         pc_ff      <= pc_in;
         bc_ff      <= bc_in;
         shift_ff   <= shift_in;
         high_ff    <= high_in;
         regaddr_ff <= regaddr_in;
         cmd_ff     <= cmd_in;
         nack_ff    <= nack_in;
         sample_ff  <= sample_in;
         half_ff    <= half_in;
      end
   end

endmodule

// File: rtl/core/i2csr_out_reg.sv
`timescale 1ns / 1ps

module i2csr_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  i2csr_pkg::rsp_type load_data,
   output logic               full,
   input  logic               take,
   output i2csr_pkg::rsp_type data
);
   import i2csr_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign full = valid_ff;
   assign data = data_ff;

endmodule

// File: tb/sv/i2c_sensor_register_reader_tb.sv
`timescale 1ns / 1ps

module i2c_sensor_register_reader_tb;
   import i2csr_pkg::*;

   // bus phases per transaction: start/stop 3 each, every byte 9 bits x 2 halves
   localparam int WAKE_PHASES = 3 + 3 * 18 + 3;
   localparam int READ_PHASES = 3 + 18 + 18 + 3 + 18 + 18 + 18 + 3;
   localparam int RANDOM_TICKS = 100;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 8;

   // how the fake slave answers on SDA while a transaction runs
   typedef enum logic [1:0] {
      SDA_RANDOM,
      SDA_ACKED,     // mostly low: acks land, read data sparse ones
      SDA_HIGH,      // no acks, reads return 0xFF bytes
      SDA_LOW
   } sda_mode_t;

   // hold = sender waits here until every result has arrived
   typedef struct packed {
      logic    hold;
      req_type tick;
   } tick_entry_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = 8'h00;   // request, command, axis_index[2:0], sda_in
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [23:0] rsp_tdata;           // scl, sda_level, sda_drive, busy, done,
                                     // sample[15:0], ack_missing

   i2c_sensor_register_reader uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Bus master model: own copy of the sequencer, stepped once per accepted
   // req transfer. Starts from the reset state of the block.
   // ---------------------------------------------------------------------
   logic [6:0]  cfg_address = DEVICE_ADDRESS_RESET;
   logic [7:0]  cfg_phase   = PHASE_TICKS_RESET;

   logic [3:0]  seq_step    = 4'd0;
   logic [7:0]  phase_cnt   = 8'd0;
   logic [3:0]  bit_cnt     = 4'd0;
   logic [7:0]  shift_reg   = 8'd0;
   logic [7:0]  upper_byte  = 8'd0;
   logic [7:0]  reg_addr    = 8'd0;
   logic        read_cmd    = 1'b0;
   logic        nack_flag   = 1'b0;
   logic [15:0] held_sample = 16'd0;
   logic        scl_high    = 1'b0;   // second (high) half of a bit

   op_type read_prog [8] = '{OP_START, OP_WADDRW, OP_WREG, OP_START,
                             OP_WADDRR, OP_RACK, OP_RNACK, OP_STOP};
   op_type wake_prog [5] = '{OP_START, OP_WADDRW, OP_W6B, OP_W00, OP_STOP};

   function automatic op_type active_op();
      op_type op;
      op = OP_IDLE;
      if (read_cmd) begin
         if (seq_step >= 4'd1 && seq_step <= READ_LEN)
            op = read_prog[3'(seq_step - 4'd1)];
      end else begin
         if (seq_step >= 4'd1 && seq_step <= WAKE_LEN)
            op = wake_prog[3'(seq_step - 4'd1)];
      end
      return op;
   endfunction

   function automatic bit is_write_op(input op_type op);
      return op >= OP_WADDRW && op <= OP_W00;
   endfunction

   task automatic load_op(input op_type op);
      phase_cnt = 8'd0;
      bit_cnt = 4'd0;
      scl_high = 1'b0;
      case (op)
         OP_WADDRW: shift_reg = {cfg_address, 1'b0};
         OP_WADDRR: shift_reg = {cfg_address, 1'b1};
         OP_WREG:   shift_reg = reg_addr;
         OP_W6B:    shift_reg = WAKE_REG;
         OP_W00:    shift_reg = WAKE_VALUE;
         OP_RACK, OP_RNACK: shift_reg = 8'd0;
         default: ;
      endcase
   endtask

   // move to the next op; finished = transaction over, sequencer idle again
   task automatic advance_op(output bit finished);
      seq_step = seq_step + 4'd1;
      finished = 1'b0;
      if (seq_step > (read_cmd ? READ_LEN : WAKE_LEN)) begin
         seq_step = 4'd0;
         phase_cnt = 8'd0;
         bit_cnt = 4'd0;
         scl_high = 1'b0;
         finished = 1'b1;
      end else begin
         load_op(active_op());
      end
   endtask

   task automatic step_bus_master(input req_type t, output rsp_type r);
      op_type op;
      int     limit;
      bit     finished;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      r.sda_drive = 1'b1;
      finished = 1'b0;

      // an idle tick with request set counts as the first tick of the start
      if (seq_step == 4'd0 && t.request) begin
         read_cmd = t.command;
         reg_addr = REG_BASE_MINUS_TWO + {4'd0, t.axis_index, 1'b0};
         nack_flag = 1'b0;
         seq_step = 4'd1;
         load_op(active_op());
      end

      op = active_op();
      if (op != OP_IDLE) begin
         r.busy_res = 1'b1;
         // line levels come from the state at the start of the tick
         if (op == OP_START) begin
            r.scl_level = bit_cnt != 4'd0;
            r.sda_level = bit_cnt != 4'd2;
         end else if (op == OP_STOP) begin
            r.scl_level = bit_cnt != 4'd0;
            r.sda_level = bit_cnt == 4'd2;
         end else begin
            r.scl_level = scl_high;
            if (is_write_op(op)) begin
               if (bit_cnt < LAST_BIT) r.sda_level = shift_reg[7];
               else r.sda_drive = 1'b0;         // slave owns the ack slot
            end else begin
               if (bit_cnt < LAST_BIT) r.sda_drive = 1'b0;
               else r.sda_level = (op == OP_RNACK);
            end
         end

         limit = (cfg_phase == 8'd0) ? 1 : int'(cfg_phase);
         if (int'(phase_cnt) + 1 < limit) begin
            phase_cnt = phase_cnt + 8'd1;
         end else begin
            phase_cnt = 8'd0;
            if (op == OP_START || op == OP_STOP) begin
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd3) advance_op(finished);
            end else if (!scl_high) begin
               scl_high = 1'b1;
            end else begin
               // end of the high half: sample SDA
               scl_high = 1'b0;
               if (is_write_op(op)) begin
                  if (bit_cnt < LAST_BIT) shift_reg = shift_reg << 1;
                  else if (t.sda_in) nack_flag = 1'b1;
               end else if (bit_cnt < LAST_BIT) begin
                  shift_reg = {shift_reg[6:0], t.sda_in};
               end else if (op == OP_RACK) begin
                  upper_byte = shift_reg;
               end else begin
                  held_sample = {upper_byte, shift_reg};
               end
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt > LAST_BIT) advance_op(finished);
            end
         end
      end

      r.done_res = finished;
      r.sample = held_sample;
      r.ack_missing = nack_flag;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus queue, expected results, counters
   // ---------------------------------------------------------------------
   tick_entry_t tick_q [$];
   rsp_type     expected_bus_q [$];
   tick_entry_t head;
   rsp_type     predicted;
   rsp_type     got;
   rsp_type     want;

   bit quiet = 1'b0;         // no idling on either side
   bit req_taken = 1'b0;     // req transfer happened at the last rising edge
   int gap_left = 0;
   int stall_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int generated_ticks = 0;
   int sent_ticks = 0;
   int done_count = 0;
   int nack_done_count = 0;
   int reads_queued = 0;
   int wakes_queued = 0;
   int random_start = 0;

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         error_count = error_count + 1;
      end
   endtask

   // Check results first, then predict the tick taken at this edge; one
   // block keeps the queue order free of races.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[21:0];
            if (expected_bus_q.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want = expected_bus_q.pop_front();
               check_field("scl_level", want.scl_level, got.scl_level);
               check_field("sda_level", want.sda_level, got.sda_level);
               check_field("sda_drive", want.sda_drive, got.sda_drive);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("done_res", want.done_res, got.done_res);
               check_field("sample", want.sample, got.sample);
               check_field("ack_missing", want.ack_missing, got.ack_missing);
               if (want.done_res) begin
                  done_count = done_count + 1;
                  if (want.ack_missing) nack_done_count = nack_done_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_bus_master(req_type'(req_tdata[5:0]), predicted);
            expected_bus_q.push_back(predicted);
            sent_ticks = sent_ticks + 1;
            req_taken = 1'b1;
         end
      end
   end

   // Sender: new data only after a transfer or while valid is low; random
   // gap after some transfers.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (tick_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (tick_q[0].hold) begin
            // pause until the block has handed back every result
            if (expected_bus_q.size() == 0) head = tick_q.pop_front();
            req_tvalid <= 1'b0;
         end else begin
            head = tick_q.pop_front();
            req_tdata <= {2'b00, head.tick};
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 13);
         end
      end
   end

   // Receiver: random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, CYCLE_LIMIT, expected_bus_q.size());
         $display("i2c_sensor_register_reader verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_tick(input logic rq, input logic cmd, input logic [2:0] axis,
                            input logic sda);
      tick_entry_t e;
      e.hold = 1'b0;
      e.tick.request = rq;
      e.tick.command = cmd;
      e.tick.axis_index = axis;
      e.tick.sda_in = sda;
      tick_q.push_back(e);
      generated_ticks = generated_ticks + 1;
   endtask

   task automatic push_hold();
      tick_entry_t e;
      e = '0;
      e.hold = 1'b1;
      tick_q.push_back(e);
   endtask

   function automatic logic slave_sda(input sda_mode_t mode);
      case (mode)
         SDA_ACKED: return $urandom_range(0, 7) == 0;
         SDA_HIGH:  return 1'b1;
         SDA_LOW:   return 1'b0;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // One whole transaction: request tick, busy ticks with ignored request
   // noise, then 0..3 idle ticks (0 = next request right after done).
   task automatic queue_transaction(input logic cmd, input logic [2:0] axis,
                                    input sda_mode_t mode);
      int len;
      len = (cmd ? READ_PHASES : WAKE_PHASES) * ((cfg_phase == 8'd0) ? 1 : int'(cfg_phase));
      if (cmd) reads_queued = reads_queued + 1;
      else wakes_queued = wakes_queued + 1;
      push_tick(1'b1, cmd, axis, slave_sda(mode));
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(0, 599) == 0) push_hold();
         push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)), slave_sda(mode));
      end
      repeat ($urandom_range(0, 3))
         push_tick(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
   endtask

   // block idle: nothing queued, nothing on the bus, nothing outstanding
   task automatic wait_drained();
      @(negedge clock);
      #1;
      while (tick_q.size() != 0 || req_tvalid || expected_bus_q.size() != 0) begin
         @(negedge clock);
         #1;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      if (idx == CSR_DEVICE_ADDRESS) cfg_address = value[6:0];
      else cfg_phase = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic sda_mode_t pick_mode();
      case ($urandom_range(0, 9))
         0:       return SDA_HIGH;
         1:       return SDA_LOW;
         2, 3, 4: return SDA_RANDOM;
         default: return SDA_ACKED;
      endcase
   endfunction

   function automatic logic [7:0] pick_phase();
      case ($urandom_range(0, 9))
         0:          return 8'd0;
         6, 7:       return 8'd2;
         8:          return 8'd3;
         9:          return 8'($urandom_range(4, 6));
         default:    return 8'd1;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short phases keep the run small; address stays at its reset value
      write_csr(CSR_PHASE_TICKS, 8'd1);
      // idle ticks: lines must sit idle high whatever the other fields say
      push_tick(1'b0, 1'b1, 3'd7, 1'b1);
      push_tick(1'b0, 1'b0, 3'd0, 1'b0);
      push_tick(1'b0, 1'b1, 3'd5, 1'b0);
      // wake at the reset address 104
      queue_transaction(1'b0, 3'd1, SDA_ACKED);

      wait_drained();
      write_csr(CSR_DEVICE_ADDRESS, 8'hFF);    // top bit of the write is dropped
      write_csr(CSR_PHASE_TICKS, 8'd1);
      queue_transaction(1'b1, 3'd0, SDA_RANDOM);   // index 0 reads 0x39, below the base
      push_hold();
      queue_transaction(1'b1, 3'd7, SDA_HIGH);     // no acks, sample reads as -1
      queue_transaction(1'b1, 3'd1, SDA_LOW);
      queue_transaction(1'b0, 3'd2, SDA_HIGH);     // wake keeps the held sample

      wait_drained();
      write_csr(CSR_DEVICE_ADDRESS, 8'h00);
      write_csr(CSR_PHASE_TICKS, 8'd0);            // zero acts as one tick
      queue_transaction(1'b1, 3'd4, SDA_RANDOM);
      queue_transaction(1'b0, 3'd6, SDA_RANDOM);

      wait_drained();
      write_csr(CSR_DEVICE_ADDRESS, {1'b0, 7'($urandom_range(0, 127))});
      write_csr(CSR_PHASE_TICKS, 8'd3);            // longer phase
      queue_transaction(1'b0, 3'd3, SDA_ACKED);

      // random phases: new settings, then a few back-to-back transactions
      random_start = generated_ticks;
      while (generated_ticks - random_start < RANDOM_TICKS) begin
         wait_drained();
         write_csr(CSR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
         write_csr(CSR_PHASE_TICKS, pick_phase());
         repeat ($urandom_range(1, 3))
            queue_transaction($urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)),
                              pick_mode());
      end

      // last stretch: no gaps, no stalls
      wait_drained();
      quiet = 1'b1;
      gap_left = 0;
      stall_left = 0;
      write_csr(CSR_PHASE_TICKS, 8'd1);
      queue_transaction(1'b1, 3'd2, SDA_ACKED);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d bus ticks: %0d reads and %0d wakes queued, %0d finished",
               sent_ticks, reads_queued, wakes_queued, done_count);
      $display("%0d finished with a missing ack; phase lengths 0 to 6, gaps, stalls, quiet tail",
               nack_done_count);
      if (error_count == 0) begin
         $display("i2c_sensor_register_reader verification clean");
      end else begin
         $display("i2c_sensor_register_reader verification failed");
      end
      $finish;
   end

endmodule
